>>> rtl/core/fsdl_pkg.sv
// Shared types, constants and helpers for the frame sync detect-and-lock block.
// Used by fsdl_front, fsdl_runs and frame_sync_detect_and_lock; depends on nothing.
package fsdl_pkg;

    localparam int FRAME_BITS = 160;
    localparam int MAX_FRAMES = 8192;
    localparam int SYNC_LEN   = 7;

    // Field widths fixed by the interface.
    localparam int POS_W   = 21;
    localparam int RUN_W   = 14;
    localparam int PHASE_W = 8;
    localparam int ERR_W   = 3;
    localparam int CFG_W   = 14;

    // One run table row holds the normal run in the low half and the inverted run above it.
    localparam int RUN_ROW_W = 2 * RUN_W;

    localparam logic [SYNC_LEN-1:0] SYNC_WORD = 7'b1010011;

    // Bit count after which no further window position can be formed.
    localparam logic [POS_W-1:0] LAST_COUNT = POS_W'(MAX_FRAMES * FRAME_BITS + SYNC_LEN - 1);
    localparam logic [POS_W-1:0] SYNC_LEN_POS = POS_W'(SYNC_LEN);
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(FRAME_BITS - 1);
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_ERR_LIMIT = 1'b0,
        CFG_MIN_CONF  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic stream_bit;
        logic start_req;
    } in_beat_t;

    typedef struct packed {
        logic               window_valid;
        logic               match;
        logic [ERR_W-1:0]   match_errors;
        logic               match_inverted;
        logic [POS_W-1:0]   match_position;
        logic               locked;
        logic [RUN_W-1:0]   confirmations;
        logic [PHASE_W-1:0] lock_phase;
        logic               lock_inverted;
        logic               overflow;
    } out_beat_t;

    // Correlator result for one bit, handed to the run-tracking stage.
    typedef struct packed {
        logic               start;
        logic               win_valid;
        logic               match;
        logic [ERR_W-1:0]   errors;
        logic               inverted;
        logic [POS_W-1:0]   position;
        logic [PHASE_W-1:0] phase;
        logic               overflow;
    } front_t;

    function automatic logic [ERR_W-1:0] ones7(input logic [SYNC_LEN-1:0] v);
        logic [ERR_W-1:0] c;
        c = '0;
        for (int i = 0; i < SYNC_LEN; i++) begin
            c = c + ERR_W'(v[i]);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/fsdl_front.sv
// Bit window, buffer position, frame phase and sync word correlator.
// Depends on fsdl_pkg.
module fsdl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  fsdl_pkg::in_beat_t                  beat,
    input  logic [fsdl_pkg::ERR_W-1:0]          err_limit,
    output fsdl_pkg::front_t                    front
);

    logic [fsdl_pkg::SYNC_LEN-1:0] win_reg, win_next, base_win, new_win;
    logic [fsdl_pkg::POS_W-1:0]    pos_reg, pos_next, base_pos, pos_inc;
    logic [fsdl_pkg::PHASE_W-1:0]  phase_reg, phase_next, base_phase;
    logic                          ovf_reg, ovf_next, base_ovf;
    logic                          drop;
    logic                          win_valid;
    logic [fsdl_pkg::ERR_W-1:0]    err_norm, err_inv;
    logic                          match_norm, match_inv;

    always_comb
    begin
        base_win   = beat.start_req ? '0 : win_reg;
        base_pos   = beat.start_req ? '0 : pos_reg;
        base_phase = beat.start_req ? '0 : phase_reg;
        base_ovf   = beat.start_req ? 1'b0 : ovf_reg;

        // Past the last window position the bit is dropped and the count saturates.
        drop     = (base_pos >= fsdl_pkg::LAST_COUNT);
        pos_inc  = base_pos + 1'b1;
        new_win  = {base_win[fsdl_pkg::SYNC_LEN-2:0], beat.stream_bit};

        win_next = drop ? base_win : new_win;
        pos_next = drop ? base_pos : pos_inc;
        ovf_next = base_ovf | drop;

        win_valid  = !drop && (pos_inc >= fsdl_pkg::SYNC_LEN_POS);
        err_norm   = fsdl_pkg::ones7(new_win ^ fsdl_pkg::SYNC_WORD);
        err_inv    = fsdl_pkg::ERR_W'(fsdl_pkg::SYNC_LEN) - err_norm;
        // Ties between the polarities go to the normal word.
        match_norm = (err_norm <= err_limit) && (err_norm <= err_inv);
        match_inv  = !match_norm && (err_inv <= err_limit);

        // The phase steps once per window formed, so it follows position mod frame.
        if (win_valid)
        begin
            phase_next = (base_phase == fsdl_pkg::LAST_PHASE) ? '0 : base_phase + 1'b1;
        end
        else
        begin
            phase_next = base_phase;
        end

        front.start     = beat.start_req;
        front.win_valid = win_valid;
        front.match     = win_valid && (match_norm || match_inv);
        front.inverted  = win_valid && match_inv;
        if (win_valid && match_norm)
        begin
            front.errors = err_norm;
        end
        else if (win_valid && match_inv)
        begin
            front.errors = err_inv;
        end
        else
        begin
            front.errors = '0;
        end
        front.position = win_valid ? (pos_inc - fsdl_pkg::SYNC_LEN_POS) : '0;
        front.phase    = base_phase;
        front.overflow = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            pos_reg   <= '0;
            phase_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            win_reg   <= win_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

>>> rtl/core/fsdl_runs.sv
// Per-phase run table (one memory row per phase, both polarities) and best-run tracker.
// Depends on fsdl_pkg.
module fsdl_runs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [fsdl_pkg::PHASE_W-1:0]        rd_phase,
    input  fsdl_pkg::front_t                    s1,
    input  logic                                s1_adv,
    input  logic [fsdl_pkg::RUN_W-1:0]          min_conf,
    output fsdl_pkg::out_beat_t                 result
);

    logic [fsdl_pkg::RUN_ROW_W-1:0]  run_mem [fsdl_pkg::FRAME_BITS];
    logic [fsdl_pkg::RUN_ROW_W-1:0]  rd_data_reg;
    logic [fsdl_pkg::FRAME_BITS-1:0] row_valid_reg, row_valid_next;

    logic [fsdl_pkg::RUN_W-1:0]   lead_run_reg, lead_run_next, base_run;
    logic [fsdl_pkg::PHASE_W-1:0] best_phase_reg, best_phase_next, base_phase;
    logic                         best_inv_reg, best_inv_next, base_inv;

    logic                         row_hit;
    logic [fsdl_pkg::RUN_W-1:0]   old_norm, old_inv, new_norm, new_inv, cand;
    logic                         better;
    logic                         wr_en;

    always_comb
    begin
        // A start beat wipes every row; its own write, if any, lands afterwards.
        row_hit  = !s1.start && row_valid_reg[s1.phase];
        old_norm = row_hit ? rd_data_reg[fsdl_pkg::RUN_W-1:0] : '0;
        old_inv  = row_hit ? rd_data_reg[fsdl_pkg::RUN_ROW_W-1:fsdl_pkg::RUN_W] : '0;

        new_norm = '0;
        new_inv  = '0;
        if (s1.match && !s1.inverted)
        begin
            new_norm = (old_norm == fsdl_pkg::RUN_MAX) ? old_norm : old_norm + 1'b1;
        end
        if (s1.match && s1.inverted)
        begin
            new_inv = (old_inv == fsdl_pkg::RUN_MAX) ? old_inv : old_inv + 1'b1;
        end
        cand = s1.inverted ? new_inv : new_norm;

        base_run   = s1.start ? '0 : lead_run_reg;
        base_phase = s1.start ? '0 : best_phase_reg;
        base_inv   = s1.start ? 1'b0 : best_inv_reg;

        // Lower phase wins a tie, then normal polarity.
        better = s1.match &&
                 ((cand > base_run) ||
                  ((cand == base_run) &&
                   ((s1.phase < base_phase) ||
                    ((s1.phase == base_phase) && !s1.inverted && base_inv))));

        lead_run_next   = better ? cand : base_run;
        best_phase_next = better ? s1.phase : base_phase;
        best_inv_next   = better ? s1.inverted : base_inv;

        wr_en = s1_adv && s1.win_valid;

        row_valid_next = s1.start ? '0 : row_valid_reg;
        if (s1.win_valid)
        begin
            row_valid_next[s1.phase] = 1'b1;
        end

        result.window_valid   = s1.win_valid;
        result.match          = s1.match;
        result.match_errors   = s1.errors;
        result.match_inverted = s1.inverted;
        result.match_position = s1.position;
        result.locked         = (lead_run_next >= min_conf);
        result.confirmations  = lead_run_next;
        result.lock_phase     = best_phase_next;
        result.lock_inverted  = best_inv_next;
        result.overflow       = s1.overflow;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            run_mem[s1.phase] <= {new_inv, new_norm};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= run_mem[rd_phase];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            lead_run_reg   <= '0;
            best_phase_reg <= '0;
            best_inv_reg   <= 1'b0;
        end
        else if (s1_adv)
        begin
            row_valid_reg  <= row_valid_next;
            lead_run_reg   <= lead_run_next;
            best_phase_reg <= best_phase_next;
            best_inv_reg   <= best_inv_next;
        end
    end

endmodule

>>> rtl/core/frame_sync_detect_and_lock.sv
// Frame sync detect-and-lock: top level with handshake, configuration and output register.
// Depends on fsdl_pkg, fsdl_front and fsdl_runs.
//
// The block takes one bit beat per clock while in_stall is low and returns one result
// beat per bit. Each bit is registered in s1_reg and its result then in the output
// register once that is free. Throughput is one bit per cycle while the output is not
// stalled, set by the run table's single read and single write port, each used at most
// once per bit; a phase row is revisited only once a frame, so no forwarding is needed.
// The table needs no clearing pass after reset or start_req: a valid bit per phase row
// marks rows written since the last clear. Configuration may be written only while no bit is in flight.
module frame_sync_detect_and_lock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  fsdl_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output fsdl_pkg::out_beat_t                 out_data,
    input  logic                                cfg_wr_en,
    input  fsdl_pkg::cfg_index_t                cfg_index,
    input  logic [fsdl_pkg::CFG_W-1:0]          cfg_data
);

    logic [fsdl_pkg::ERR_W-1:0] err_limit_reg;
    logic [fsdl_pkg::RUN_W-1:0] min_conf_reg;

    fsdl_pkg::front_t    front;
    fsdl_pkg::front_t    s1_reg;
    logic                s1_valid_reg;
    fsdl_pkg::out_beat_t result;
    fsdl_pkg::out_beat_t out_data_reg;
    logic                out_valid_reg;

    logic out_free;
    logic s1_adv;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_limit_reg <= fsdl_pkg::ERR_W'(1);
            min_conf_reg  <= fsdl_pkg::RUN_W'(3);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fsdl_pkg::CFG_ERR_LIMIT: err_limit_reg <= cfg_data[fsdl_pkg::ERR_W-1:0];
                fsdl_pkg::CFG_MIN_CONF:  min_conf_reg  <= cfg_data[fsdl_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    fsdl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .beat      (in_data),
        .err_limit (err_limit_reg),
        .front     (front)
    );

    fsdl_runs u_runs (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_phase (front.phase),
        .s1       (s1_reg),
        .s1_adv   (s1_adv),
        .min_conf (min_conf_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= front;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> sim/tb_frame_sync_detect_and_lock.sv
// Testbench for frame_sync_detect_and_lock: drives a raw bitstream and checks every result beat.
// A scoreboard class predicts each beat from its own copy of the lock state.
// Depends on fsdl_pkg and the RTL of frame_sync_detect_and_lock.
`timescale 1ns / 1ps

module tb_frame_sync_detect_and_lock;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 40;
    localparam int REGIME_BITS    = 170;
    localparam int LONG_BITS      = 330;

    class sync_lock_scoreboard;
        logic [fsdl_pkg::ERR_W-1:0]    max_err;
        logic [fsdl_pkg::CFG_W-1:0]    min_conf;
        logic [fsdl_pkg::SYNC_LEN-1:0] window;
        logic [fsdl_pkg::POS_W-1:0]    bits_taken;
        logic [fsdl_pkg::RUN_W-1:0]    runs [2*fsdl_pkg::FRAME_BITS];
        logic [fsdl_pkg::RUN_W-1:0]    top_run;
        logic [fsdl_pkg::PHASE_W-1:0]  best_phase;
        logic                          best_inv;
        logic                          ovf;
        fsdl_pkg::out_beat_t           beats_due[$];
        int                            mismatches;
        int                            beat_no;

        function new();
            max_err    = fsdl_pkg::ERR_W'(1);
            min_conf   = fsdl_pkg::CFG_W'(3);
            mismatches = 0;
            beat_no    = 0;
            clear();
        endfunction

        function void clear();
            window     = '0;
            bits_taken = '0;
            foreach (runs[i])
                runs[i] = '0;
            top_run    = '0;
            best_phase = '0;
            best_inv   = 1'b0;
            ovf        = 1'b0;
        endfunction

        function void write_reg(fsdl_pkg::cfg_index_t idx, logic [fsdl_pkg::CFG_W-1:0] val);
            case (idx)
                fsdl_pkg::CFG_ERR_LIMIT: max_err = val[fsdl_pkg::ERR_W-1:0];
                fsdl_pkg::CFG_MIN_CONF:  min_conf = val;
                default:                 ;
            endcase
        endfunction

        function bit drained();
            return beats_due.size() == 0;
        endfunction

        // Works out the result beat for one accepted input bit.
        function void take_bit(fsdl_pkg::in_beat_t b);
            fsdl_pkg::out_beat_t        exp;
            logic [fsdl_pkg::POS_W-1:0] pos;
            logic [fsdl_pkg::ERR_W-1:0] err_n;
            logic [fsdl_pkg::ERR_W-1:0] err_i;
            logic                       hit;
            logic                       inv;
            logic [fsdl_pkg::RUN_W-1:0] r;
            int                         ph;
            int                         idx;
            exp = '0;
            if (b.start_req)
                clear();
            if (bits_taken >= fsdl_pkg::LAST_COUNT)
            begin
                ovf = 1'b1;
            end
            else
            begin
                window = {window[fsdl_pkg::SYNC_LEN-2:0], b.stream_bit};
                bits_taken = bits_taken + 1'b1;
                if (bits_taken >= fsdl_pkg::SYNC_LEN_POS)
                begin
                    pos = bits_taken - fsdl_pkg::SYNC_LEN_POS;
                    err_n = fsdl_pkg::ERR_W'($countones(window ^ fsdl_pkg::SYNC_WORD));
                    err_i = fsdl_pkg::ERR_W'(fsdl_pkg::SYNC_LEN) - err_n;
                    hit = 1'b0;
                    inv = 1'b0;
                    exp.window_valid = 1'b1;
                    exp.match_position = pos;
                    if (err_n <= max_err && err_n <= err_i)
                    begin
                        hit = 1'b1;
                        exp.match_errors = err_n;
                    end
                    else if (err_i <= max_err)
                    begin
                        hit = 1'b1;
                        inv = 1'b1;
                        exp.match_errors = err_i;
                    end
                    exp.match = hit;
                    exp.match_inverted = inv;
                    ph = int'(pos % fsdl_pkg::POS_W'(fsdl_pkg::FRAME_BITS));
                    for (int k = 0; k < 2; k++)
                    begin
                        idx = 2 * ph + k;
                        if (hit && inv == k)
                        begin
                            r = runs[idx];
                            if (r < fsdl_pkg::RUN_MAX)
                                r = r + 1'b1;
                            runs[idx] = r;
                            // Longer run wins; on a tie the lower phase, then normal polarity.
                            if (r > top_run || (r == top_run && (ph < best_phase ||
                                (ph == best_phase && k < best_inv))))
                            begin
                                top_run    = r;
                                best_phase = fsdl_pkg::PHASE_W'(ph);
                                best_inv   = k[0];
                            end
                        end
                        else
                        begin
                            runs[idx] = '0;
                        end
                    end
                end
            end
            exp.locked        = (top_run >= min_conf);
            exp.confirmations = top_run;
            exp.lock_phase    = best_phase;
            exp.lock_inverted = best_inv;
            exp.overflow      = ovf;
            beats_due.insert(beats_due.size(), exp);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (mismatches < PRINT_LIMIT)
                $display("%0t ns: beat %0d %s: got %0h, want %0h",
                         $time, beat_no, what, got, want);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report(name, got, want);
        endtask

        task check_beat(fsdl_pkg::out_beat_t got);
            fsdl_pkg::out_beat_t exp;
            if (beats_due.size() == 0)
            begin
                report("result beat with nothing pending", 32'(got), 32'd0);
            end
            else
            begin
                exp = beats_due.pop_front();
                check_field("window_valid", 32'(got.window_valid), 32'(exp.window_valid));
                check_field("match", 32'(got.match), 32'(exp.match));
                check_field("match_errors", 32'(got.match_errors), 32'(exp.match_errors));
                check_field("match_inverted", 32'(got.match_inverted),
                            32'(exp.match_inverted));
                check_field("match_position", 32'(got.match_position),
                            32'(exp.match_position));
                check_field("locked", 32'(got.locked), 32'(exp.locked));
                check_field("confirmations", 32'(got.confirmations),
                            32'(exp.confirmations));
                check_field("lock_phase", 32'(got.lock_phase), 32'(exp.lock_phase));
                check_field("lock_inverted", 32'(got.lock_inverted),
                            32'(exp.lock_inverted));
                check_field("overflow", 32'(got.overflow), 32'(exp.overflow));
            end
            beat_no++;
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    fsdl_pkg::in_beat_t         in_data = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    fsdl_pkg::out_beat_t        out_data;
    logic                       cfg_wr_en = 1'b0;
    fsdl_pkg::cfg_index_t       cfg_index = fsdl_pkg::CFG_ERR_LIMIT;
    logic [fsdl_pkg::CFG_W-1:0] cfg_data = '0;

    sync_lock_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    frame_sync_detect_and_lock dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver side: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Results are checked before the input of the same edge is noted.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_stall == 1'b0)
            sb.check_beat(out_data);
        if (in_valid && in_stall === 1'b0)
            sb.take_bit(in_data);
        if ((out_valid === 1'b1 && out_stall == 1'b0) || (in_valid && in_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_bit(input logic sbit, input logic st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= fsdl_pkg::in_beat_t'{stream_bit: sbit, start_req: st};
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [fsdl_pkg::ERR_W-1:0] me,
                              input logic [fsdl_pkg::CFG_W-1:0] mc);
        cfg_wr_en <= 1'b1;
        cfg_index <= fsdl_pkg::CFG_ERR_LIMIT;
        cfg_data <= fsdl_pkg::CFG_W'(me);
        @(posedge clk);
        cfg_index <= fsdl_pkg::CFG_MIN_CONF;
        cfg_data <= mc;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(fsdl_pkg::CFG_ERR_LIMIT, fsdl_pkg::CFG_W'(me));
        sb.write_reg(fsdl_pkg::CFG_MIN_CONF, mc);
    endtask

    // Waits until every pending beat has come back.
    task automatic settle();
        while (!sb.drained())
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config();
        logic [fsdl_pkg::ERR_W-1:0] me;
        logic [fsdl_pkg::CFG_W-1:0] mc;
        int pick;
        me = ($urandom_range(9) < 6) ? fsdl_pkg::ERR_W'($urandom_range(2))
                                      : fsdl_pkg::ERR_W'($urandom_range(7));
        pick = $urandom_range(19);
        if (pick == 0)
            mc = fsdl_pkg::CFG_W'(fsdl_pkg::MAX_FRAMES);
        else if (pick == 1)
            mc = fsdl_pkg::CFG_W'($urandom_range(fsdl_pkg::MAX_FRAMES));
        else
            mc = fsdl_pkg::CFG_W'($urandom_range(4));
        set_config(me, mc);
    endtask

    // One buffer: a start bit, then zero, one or two sync streams at fixed phases in noise.
    // The long form keeps one clean stream with a single bit error every fifth frame.
    task automatic run_buffer(input int nbits, input bit long_run);
        int   ph_a;
        int   ph_b;
        int   streams;
        int   flip_pct;
        int   d;
        logic pol_a;
        logic pol_b;
        logic sbit;
        logic st;
        ph_a = $urandom_range(fsdl_pkg::FRAME_BITS - 1);
        ph_b = $urandom_range(fsdl_pkg::FRAME_BITS - 1);
        pol_a = 1'($urandom_range(1));
        pol_b = 1'($urandom_range(1));
        if (long_run)
            streams = 1;
        else if ($urandom_range(9) == 0)
            streams = 0;
        else
            streams = ($urandom_range(3) == 0) ? 2 : 1;
        flip_pct = long_run ? 0 : int'($urandom_range(8));
        for (int i = 0; i < nbits; i++)
        begin
            sbit = 1'($urandom_range(1));
            st = (i == 0) || (!long_run && $urandom_range(399) == 0);
            if (streams >= 1)
            begin
                d = (i % fsdl_pkg::FRAME_BITS + fsdl_pkg::FRAME_BITS - ph_a)
                    % fsdl_pkg::FRAME_BITS;
                if (d < fsdl_pkg::SYNC_LEN)
                begin
                    sbit = fsdl_pkg::SYNC_WORD[fsdl_pkg::SYNC_LEN-1-d] ^ pol_a ^
                           ($urandom_range(99) < flip_pct);
                    // A single bit error every fifth frame still lies within one error.
                    if (long_run && d == 3 && (i / fsdl_pkg::FRAME_BITS) % 5 == 0)
                        sbit = ~sbit;
                end
            end
            if (streams == 2)
            begin
                d = (i % fsdl_pkg::FRAME_BITS + fsdl_pkg::FRAME_BITS - ph_b)
                    % fsdl_pkg::FRAME_BITS;
                if (d < fsdl_pkg::SYNC_LEN)
                    sbit = fsdl_pkg::SYNC_WORD[fsdl_pkg::SYNC_LEN-1-d] ^ pol_b ^
                           ($urandom_range(99) < flip_pct);
            end
            send_bit(sbit, st);
        end
    endtask

    initial
    begin
        int sent;
        int nbits;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: exact word, exact inverse, a one-bit error, then a restart mid-stream.
        send_idle_pct = 31;
        recv_idle_pct = 66;
        for (int k = 0; k < fsdl_pkg::SYNC_LEN; k++)
            send_bit(fsdl_pkg::SYNC_WORD[fsdl_pkg::SYNC_LEN-1-k], k == 0);
        for (int k = 0; k < fsdl_pkg::SYNC_LEN; k++)
            send_bit(~fsdl_pkg::SYNC_WORD[fsdl_pkg::SYNC_LEN-1-k], 1'b0);
        for (int k = 0; k < fsdl_pkg::SYNC_LEN; k++)
            send_bit(fsdl_pkg::SYNC_WORD[fsdl_pkg::SYNC_LEN-1-k] ^ (k == 3), 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        in_valid <= 1'b0;
        settle();

        for (int regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 31 : (regime == 1) ? 66 : 0;
            recv_idle_pct = (regime == 0) ? 66 : (regime == 1) ? 31 : 0;
            sent = 0;
            while (sent < REGIME_BITS)
            begin
                nbits = $urandom_range(60, REGIME_BITS);
                if (nbits > REGIME_BITS - sent)
                    nbits = REGIME_BITS - sent;
                if (sent == 0 && regime == 0)
                    set_config(3'd0, 14'd0);
                else if (sent == 0 && regime == 1)
                    set_config(3'd7, fsdl_pkg::CFG_W'(fsdl_pkg::MAX_FRAMES));
                else
                    random_config();
                // Hold the receiver off while the sender keeps offering beats.
                if (sent == 0 && regime == 2)
                    hold_left = 200;
                run_buffer(nbits, 1'b0);
                in_valid <= 1'b0;
                settle();
                sent += nbits;
            end
        end

        // One clean stream long enough for a run of two frames, so that lock is reached.
        set_config(3'd1, 14'd2);
        run_buffer(LONG_BITS, 1'b1);
        in_valid <= 1'b0;
        settle();

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
